>>> hdl/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 stream decoder.
// Has no dependencies; every other module of the block imports it.
package u8u16_pkg;

	// One Unicode code point, wide enough for any four-byte sequence.
	typedef logic [20:0] cp_t;

	localparam cp_t         CP_MAX    = 21'h10FFFF;
	localparam cp_t         SUPP_BASE = 21'h010000;
	localparam logic [15:0] HI_SURR   = 16'hD800;
	localparam logic [15:0] LO_SURR   = 16'hDC00;

	// Front part to queue: one finished code point.
	typedef struct packed {
		logic valid;
		cp_t  cp;
	} cp_push_t;

	// Queue to back part: the oldest queued code point.
	typedef struct packed {
		logic valid;
		cp_t  cp;
	} cp_head_t;

endpackage

>>> hdl/utf8_to_utf16_stream_decoder.sv
// Top level of the UTF-8 to UTF-16 stream decoder.
// Depends on u8u16_pkg, u8u16_front, u8u16_fifo and u8u16_back.
//
// The decoder takes one UTF-8 byte per transfer on the slave side and
// produces UTF-16 code units on the master side. A byte is accepted in
// every cycle in which the code point queue has room, so a stream of
// one-to-three-byte characters flows at one byte per clock. A code point
// from 0x10000 to 0x10FFFF leaves as a surrogate pair, high half first,
// and takes two output beats; the input pauses only when the
// FIFO_DEPTH-entry queue fills. A finished code point is written into
// the queue when the byte that finished it is transferred, and its unit
// is then registered from the queue head into the single output
// register; the low half of a pair follows once the high half has been
// taken. tlast on the output is set on the last unit that one input
// byte produced. Invalid lead bytes and code points above 0x10FFFF are
// consumed without output; a bad continuation byte drops the open
// sequence and is decoded again as a lead; a sequence still open at a
// byte carrying tlast is dropped. There are no checks for overlong forms
// or encoded surrogates.
module utf8_to_utf16_stream_decoder #(
	parameter int FIFO_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // string_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] code_unit
	output logic        m_tlast    // run_last
);
	import u8u16_pkg::*;

	cp_push_t push;
	cp_head_t head;
	logic     room;
	logic     pop;

	// Front part: sequence tracking and code point assembly.
	u8u16_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.room       (room),
		.data_byte  (s_tdata),
		.string_end (s_tlast),
		.in_ready   (s_tready),
		.push       (push)
	);

	// Queue that lets the input run on while a surrogate pair drains.
	u8u16_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.room   (room),
		.head   (head)
	);

	// Back part: UTF-16 unit generation into the output register.
	u8u16_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.code_unit (m_tdata),
		.run_last  (m_tlast)
	);

endmodule

>>> hdl/u8u16_front.sv
// Front part: accepts UTF-8 bytes, tracks the open sequence and pushes each
// finished code point that fits in UTF-16. Depends on u8u16_pkg.
module u8u16_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                room,
	input  logic [7:0]          data_byte,
	input  logic                string_end,
	output logic                in_ready,
	output u8u16_pkg::cp_push_t push
);
	import u8u16_pkg::*;

	cp_t        partial_q;
	logic [1:0] remaining_q;
	cp_t        partial_nxt;
	logic [1:0] remaining_nxt;
	cp_t        acc;
	cp_t        cp_val;
	logic       cp_done;
	logic       as_lead;
	logic       accept;

	assign in_ready = room;
	assign accept   = in_valid & room;
	assign acc      = {partial_q[14:0], data_byte[5:0]};

	always_comb begin
		partial_nxt   = partial_q;
		remaining_nxt = remaining_q;
		cp_val        = '0;
		cp_done       = 1'b0;
		as_lead       = 1'b1;
		if (remaining_q != 2'd0) begin
			if (data_byte[7:6] == 2'b10) begin
				as_lead       = 1'b0;
				partial_nxt   = acc;
				remaining_nxt = remaining_q - 2'd1;
				if (remaining_q == 2'd1) begin
					cp_done     = 1'b1;
					cp_val      = acc;
					partial_nxt = '0;
				end
			end else begin
				// A broken sequence is dropped and the byte starts over as a lead.
				partial_nxt   = '0;
				remaining_nxt = 2'd0;
			end
		end
		if (as_lead) begin
			unique casez (data_byte)
				8'b0???????: begin
					cp_done = 1'b1;
					cp_val  = {13'd0, data_byte};
				end
				8'b110?????: begin
					partial_nxt   = {16'd0, data_byte[4:0]};
					remaining_nxt = 2'd1;
				end
				8'b1110????: begin
					partial_nxt   = {17'd0, data_byte[3:0]};
					remaining_nxt = 2'd2;
				end
				8'b11110???: begin
					partial_nxt   = {18'd0, data_byte[2:0]};
					remaining_nxt = 2'd3;
				end
				default: begin
					// Stray continuation or invalid lead byte: nothing happens.
				end
			endcase
		end
		if (string_end && remaining_nxt != 2'd0) begin
			partial_nxt   = '0;
			remaining_nxt = 2'd0;
		end
	end

	assign push.valid = accept & cp_done & (cp_val <= CP_MAX);
	assign push.cp    = cp_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q   <= '0;
			remaining_q <= 2'd0;
		end else if (accept) begin
			partial_q   <= partial_nxt;
			remaining_q <= remaining_nxt;
		end
	end

endmodule

>>> hdl/u8u16_fifo.sv
// Short code point queue between the front and back parts.
// Depends on u8u16_pkg.
module u8u16_fifo #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  u8u16_pkg::cp_push_t push,
	input  logic                pop,
	output logic                room,
	output u8u16_pkg::cp_head_t head
);
	import u8u16_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	cp_t             mem [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_pop;

	assign room       = (count_q != CntW'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.cp    = mem[rd_ptr_q];
	assign do_pop     = pop & head.valid;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem[wr_ptr_q] <= push.cp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push.valid && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push.valid && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/u8u16_back.sv
// Back part: turns queued code points into UTF-16 units in an output
// register, two beats for a surrogate pair. Depends on u8u16_pkg.
module u8u16_back (
	input  logic                clk,
	input  logic                arst_n,
	input  u8u16_pkg::cp_head_t head,
	output logic                pop,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [15:0]         code_unit,
	output logic                run_last
);
	import u8u16_pkg::*;

	logic        valid_q;
	logic [15:0] unit_q;
	logic        last_q;
	logic        low_pending_q;
	logic        load;
	cp_t         offset;
	logic [15:0] hi_unit;
	logic [15:0] lo_unit;
	logic        is_bmp;

	assign offset  = head.cp - SUPP_BASE;
	assign hi_unit = HI_SURR + {6'd0, offset[19:10]};
	assign lo_unit = LO_SURR + {6'd0, offset[9:0]};
	assign is_bmp  = (head.cp[20:16] == 5'd0);
	assign load    = !valid_q || out_ready;
	// The entry leaves the queue with its last unit.
	assign pop     = load & head.valid & (low_pending_q | is_bmp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= 1'b0;
			low_pending_q <= 1'b0;
		end else if (load) begin
			valid_q <= head.valid;
			if (head.valid) begin
				low_pending_q <= !low_pending_q && !is_bmp;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head.valid) begin
			if (low_pending_q) begin
				unit_q <= lo_unit;
				last_q <= 1'b1;
			end else if (is_bmp) begin
				unit_q <= head.cp[15:0];
				last_q <= 1'b1;
			end else begin
				unit_q <= hi_unit;
				last_q <= 1'b0;
			end
		end
	end

	assign out_valid = valid_q;
	assign code_unit = unit_q;
	assign run_last  = last_q;

endmodule

>>> dv/tb_utf8_to_utf16_stream_decoder.sv
// Self-checking testbench for utf8_to_utf16_stream_decoder: directed byte table, then random
// UTF-8 traffic under changing idle patterns, checked against a behavioral decoder or typed units.
// Depends on u8u16_pkg and the RTL of the decoder; reads no files.
module tb_utf8_to_utf16_stream_decoder;
	import u8u16_pkg::*;

	// Byte classes of UTF-8, written as mask and tag pairs.
	localparam logic [7:0] CONT_MASK   = 8'hC0;
	localparam logic [7:0] CONT_TAG    = 8'h80;
	localparam logic [7:0] LEAD2_MASK  = 8'hE0;
	localparam logic [7:0] LEAD2_TAG   = 8'hC0;
	localparam logic [7:0] LEAD3_MASK  = 8'hF0;
	localparam logic [7:0] LEAD3_TAG   = 8'hE0;
	localparam logic [7:0] LEAD4_MASK  = 8'hF8;
	localparam logic [7:0] LEAD4_TAG   = 8'hF0;
	localparam cp_t        BMP_MAX     = 21'h00FFFF;
	localparam cp_t        CP_FIELD_MAX = 21'h1FFFFF;

	localparam int RANDOM_BYTES = 750;  // useful random bytes before the stimulus stops
	localparam int HOLD_CYCLES  = 64;   // long receiver stall that backs up the input
	localparam int QUIET_LIMIT  = 2000; // cycles without any transfer before giving up
	localparam int DRAIN_CYCLES = 20;   // settle time after the last expected unit

	// One expected UTF-16 code unit with its end-of-byte flag.
	typedef struct packed {
		logic [15:0] code_unit;
		logic        run_last;
	} unit_t;

	// One row of the directed table. When typed is set, the expected units are written
	// into the row itself; otherwise the decoder model supplies them.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       string_end;
		logic       typed;
		logic [1:0] n_units;
		unit_t      first;
		unit_t      second;
	} row_t;

	localparam unit_t NO_UNIT = '{16'h0000, 1'b0};
	localparam int    N_ROWS  = 25;

	localparam row_t DIRECTED_BYTES [N_ROWS] = '{
		// Smallest and largest ASCII bytes; the second also closes a string.
		'{8'h00, 1'b0, 1'b1, 2'd1, '{16'h0000, 1'b1}, NO_UNIT},
		'{8'h7F, 1'b1, 1'b1, 2'd1, '{16'h007F, 1'b1}, NO_UNIT},
		// Largest byte value is an invalid lead and is dropped.
		'{8'hFF, 1'b0, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
		// Two-byte sequence for U+00A9.
		'{8'hC2, 1'b0, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
		'{8'hA9, 1'b0, 1'b1, 2'd1, '{16'h00A9, 1'b1}, NO_UNIT},
		// Three-byte sequence for U+20AC.
		'{8'hE2, 1'b0, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
		'{8'h82, 1'b0, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
		'{8'hAC, 1'b0, 1'b1, 2'd1, '{16'h20AC, 1'b1}, NO_UNIT},
		// Four-byte sequence for U+1F600 leaves as a surrogate pair.
		'{8'hF0, 1'b0, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
		'{8'h9F, 1'b0, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
		'{8'h98, 1'b0, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
		'{8'h80, 1'b0, 1'b1, 2'd2, '{16'hD83D, 1'b0}, '{16'hDE00, 1'b1}},
		// Highest legal code point, U+10FFFF.
		'{8'hF4, 1'b0, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
		'{8'h8F, 1'b0, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
		'{8'hBF, 1'b0, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
		'{8'hBF, 1'b0, 1'b1, 2'd2, '{16'hDBFF, 1'b0}, '{16'hDFFF, 1'b1}},
		// One past the top, 0x110000, is consumed without output.
		'{8'hF4, 1'b0, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
		'{8'h90, 1'b0, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
		'{8'h80, 1'b0, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
		'{8'h80, 1'b0, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
		// Bad continuation: the ASCII byte kills the open sequence and is decoded itself.
		'{8'hE2, 1'b0, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
		'{8'h41, 1'b0, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
		// Sequence still open at the end of a string is dropped, so the continuation
		// byte that follows is a stray lead.
		'{8'hE2, 1'b0, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
		'{8'h82, 1'b1, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
		'{8'hAC, 1'b0, 1'b1, 2'd0, NO_UNIT, NO_UNIT}
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic        s_tlast;   // string_end
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [15:0] code_unit
	logic        m_tlast;   // run_last

	utf8_to_utf16_stream_decoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Decoder state kept by the testbench: code point bits gathered so far and the
	// number of continuation bytes still owed.
	cp_t        open_cp;
	logic [1:0] owed_conts;

	// Code units the decoder still has to deliver, oldest first.
	unit_t pending_units [$];

	int error_count = 0;
	int bytes_sent;
	int useful_bytes;
	int stray_leads;
	int units_checked = 0;
	int pairs_expected;
	int tx_idle_pct;
	int rx_stall_pct;
	logic hold_req;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int quiet_cycles = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Turns a finished code point into zero, one or two UTF-16 units.
	function automatic int split_code_point(input cp_t cp, output unit_t hi, output unit_t lo);
		cp_t off;
		hi = NO_UNIT;
		lo = NO_UNIT;
		off = cp - SUPP_BASE;
		if (cp <= BMP_MAX) begin
			hi.code_unit = cp[15:0];
			hi.run_last = 1'b1;
			return 1;
		end
		if (cp <= CP_MAX) begin
			hi.code_unit = HI_SURR + {6'd0, off[19:10]};
			hi.run_last = 1'b0;
			lo.code_unit = LO_SURR + {6'd0, off[9:0]};
			lo.run_last = 1'b1;
			return 2;
		end
		return 0;
	endfunction

	// Advances the decoder state by one byte and returns the number of units it yields.
	// stray is set for a byte that is dropped while no sequence is open.
	function automatic int decode_byte(input logic [7:0] b, input logic fin,
			output unit_t first, output unit_t second, output bit stray);
		int n;
		bit as_lead;
		n = 0;
		as_lead = 1'b1;
		stray = 1'b0;
		first = NO_UNIT;
		second = NO_UNIT;
		if (owed_conts != 2'd0) begin
			if ((b & CONT_MASK) == CONT_TAG) begin
				open_cp = {open_cp[14:0], b[5:0]};
				owed_conts = owed_conts - 2'd1;
				if (owed_conts == 2'd0) begin
					n = split_code_point(open_cp, first, second);
					open_cp = '0;
				end
				as_lead = 1'b0;
			end else begin
				// Not a continuation: forget the sequence and treat the byte as a lead.
				open_cp = '0;
				owed_conts = 2'd0;
			end
		end
		if (as_lead) begin
			if (!b[7]) begin
				n = split_code_point({13'd0, b}, first, second);
			end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
				open_cp = {16'd0, b[4:0]};
				owed_conts = 2'd1;
			end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
				open_cp = {17'd0, b[3:0]};
				owed_conts = 2'd2;
			end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
				open_cp = {18'd0, b[2:0]};
				owed_conts = 2'd3;
			end else begin
				stray = 1'b1;
			end
		end
		if (fin && owed_conts != 2'd0) begin
			open_cp = '0;
			owed_conts = 2'd0;
		end
		return n;
	endfunction

	// Offers one byte, waits for its transfer and queues the units it should produce.
	// Directed rows may pass their own expectation; the model state advances either way.
	task automatic send_byte(input logic [7:0] b, input logic fin, input bit typed,
			input logic [1:0] typed_n, input unit_t typed_first, input unit_t typed_second);
		int n;
		unit_t first;
		unit_t second;
		bit stray;
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= fin;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		n = decode_byte(b, fin, first, second, stray);
		if (typed) begin
			n = typed_n;
			first = typed_first;
			second = typed_second;
		end
		if (n > 0)
			pending_units.push_back(first);
		if (n > 1) begin
			pending_units.push_back(second);
			pairs_expected++;
		end
		bytes_sent++;
		if (stray)
			stray_leads++;
		else
			useful_bytes++;
	endtask

	// Encodes a code point in len bytes (overlong forms allowed) and sends the first
	// keep of them. string_end rides on the last byte sent when fin is set.
	task automatic send_sequence(input cp_t cp, input int len, input int keep, input logic fin);
		logic [7:0] enc [4];
		case (len)
			1: begin
				enc[0] = {1'b0, cp[6:0]};
			end
			2: begin
				enc[0] = LEAD2_TAG | {3'd0, cp[10:6]};
				enc[1] = CONT_TAG | {2'd0, cp[5:0]};
			end
			3: begin
				enc[0] = LEAD3_TAG | {4'd0, cp[15:12]};
				enc[1] = CONT_TAG | {2'd0, cp[11:6]};
				enc[2] = CONT_TAG | {2'd0, cp[5:0]};
			end
			default: begin
				enc[0] = LEAD4_TAG | {5'd0, cp[20:18]};
				enc[1] = CONT_TAG | {2'd0, cp[17:12]};
				enc[2] = CONT_TAG | {2'd0, cp[11:6]};
				enc[3] = CONT_TAG | {2'd0, cp[5:0]};
			end
		endcase
		for (int k = 0; k < keep; k++)
			send_byte(enc[k], fin && (k == keep - 1), 1'b0, 2'd0, NO_UNIT, NO_UNIT);
	endtask

	// Receiver side. Stalls at the rate of the current phase, and once, when asked, holds
	// off for a long stretch so that the decoder's queue fills and its input stalls.
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Every output transfer is compared with the oldest pending unit.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_units.size() == 0) begin
				$error("unexpected code unit %h (tlast %b) with nothing pending", m_tdata, m_tlast);
				error_count++;
			end else begin
				if (m_tdata !== pending_units[0].code_unit) begin
					$error("code_unit: expected %h, got %h",
						pending_units[0].code_unit, m_tdata);
					error_count++;
				end
				if (m_tlast !== pending_units[0].run_last) begin
					$error("run_last: expected %b, got %b", pending_units[0].run_last, m_tlast);
					error_count++;
				end
				void'(pending_units.pop_front());
				units_checked++;
			end
		end
	end

	// Watchdog: the run ends if no transfer happens on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no transfer for %0d cycles, %0d units pending",
				quiet_cycles, pending_units.size());
			$display("utf8_to_utf16_stream_decoder test failed");
			$finish;
		end
	end

	initial begin
		int kind;
		int len;
		int keep;
		cp_t cp;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tlast = 1'b0;
		hold_req = 1'b0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		open_cp = '0;
		owed_conts = 2'd0;
		bytes_sent = 0;
		useful_bytes = 0;
		stray_leads = 0;
		pairs_expected = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table, both sides always ready.
		for (int r = 0; r < N_ROWS; r++)
			send_byte(DIRECTED_BYTES[r].data_byte, DIRECTED_BYTES[r].string_end,
				DIRECTED_BYTES[r].typed, DIRECTED_BYTES[r].n_units,
				DIRECTED_BYTES[r].first, DIRECTED_BYTES[r].second);

		// Random traffic in three thirds: slow receiver, then slow sender, then full
		// speed with one long receiver hold-off at its start.
		useful_bytes = 0;
		while (useful_bytes < RANDOM_BYTES) begin
			if (useful_bytes < RANDOM_BYTES / 3) begin
				tx_idle_pct = 24;
				rx_stall_pct <= 70;
			end else if (useful_bytes < 2 * RANDOM_BYTES / 3) begin
				tx_idle_pct = 70;
				rx_stall_pct <= 24;
			end else begin
				tx_idle_pct = 0;
				rx_stall_pct <= 0;
				hold_req <= 1'b1;
			end
			kind = $urandom_range(99);
			len = $urandom_range(1, 4);
			case (len)
				1: cp = cp_t'($urandom_range(0, 'h7F));
				2: cp = cp_t'($urandom_range(0, 'h7FF));
				3: cp = cp_t'($urandom_range(0, 'hFFFF));
				default: begin
					// Mostly legal supplementary points, sometimes beyond the top.
					if ($urandom_range(3) == 0)
						cp = cp_t'($urandom_range(0, CP_FIELD_MAX));
					else
						cp = cp_t'($urandom_range(SUPP_BASE, CP_MAX));
				end
			endcase
			if (kind < 75) begin
				// Well-formed character, occasionally closing a string.
				send_sequence(cp, len, len, $urandom_range(7) == 0);
			end else if (kind < 88) begin
				// Truncated multi-byte sequence; half of them end the string early,
				// the rest run into whatever follows as a bad continuation.
				len = $urandom_range(2, 4);
				keep = $urandom_range(1, len - 1);
				send_sequence(cp, len, keep, 1'($urandom_range(1)));
			end else begin
				// Raw noise byte.
				send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(1)), 1'b0, 2'd0,
					NO_UNIT, NO_UNIT);
			end
		end
		s_tvalid <= 1'b0;

		while (pending_units.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes (%0d dropped as stray leads) across three idle patterns.",
			bytes_sent, stray_leads);
		$display("Checked %0d UTF-16 units, including %0d surrogate pairs.",
			units_checked, pairs_expected);
		if (error_count == 0)
			$display("utf8_to_utf16_stream_decoder test passed");
		else
			$display("utf8_to_utf16_stream_decoder test failed");
		$finish;
	end

endmodule
